// File: rtl/fisd_pkg.sv
`default_nettype none
package fisd_pkg;

	localparam int NDIG = 20;
	localparam int BCDW = NDIG * 4;
	localparam int DABBLE_STAGES = 8;
	localparam int BITS_PER_STAGE = 64 / DABBLE_STAGES;

	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_DOUBLE = 2'd1,
		KIND_BF16   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// sideband that travels beside the magnitude
	typedef struct packed {
		logic       nh;
		logic       neg;
		logic       rnd;
		logic [3:0] shift;
		logic [9:0] lo;
		logic [9:0] hi;
	} side_t;

	// one add-3 and shift step of the binary to bcd conversion
	function automatic logic [BCDW-1:0] dd_step(input logic [BCDW-1:0] b, input logic bit_in);
		logic [BCDW-1:0] t;
		t = b;
		for (int i = 0; i < NDIG; i++) begin
			if (t[i*4 +: 4] >= 4'd5) begin
				t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
			end
		end
		return {t[BCDW-2:0], bit_in};
	endfunction

endpackage
`default_nettype wire

// File: rtl/fisd_decode.sv
`default_nettype none
module fisd_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                v_in,
	input  wire logic [1:0]          kind,
	input  wire logic [63:0]         bits,
	output logic                     v_s2,
	output logic [63:0]              mag_s2,
	output fisd_pkg::side_t          side_s2
);
	import fisd_pkg::*;

	logic        v_s1;
	logic [1:0]  kind_s1;
	logic [63:0] bits_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			bits_s1 <= bits;
		end
	end

	logic [31:0]        b32;
	logic [11:0]        field;
	logic [63:0]        mant;
	logic               neg;
	logic [5:0]         mb;
	logic [10:0]        bias;
	logic [5:0]         maxe;
	logic signed [13:0] ex;
	logic [63:0]        full;
	logic [5:0]         rsh;
	logic [5:0]         lsh;
	logic [63:0]        fmask;
	logic [63:0]        mag;
	logic [3:0]         shift;
	logic [9:0]         half;
	logic [9:0]         lower;
	side_t              side;

	// field extraction per format
	always_comb begin
		b32 = (kind_s1 == KIND_BF16) ? {bits_s1[15:0], 16'h0000} : bits_s1[31:0];
		if (kind_s1 == KIND_DOUBLE) begin
			field = {1'b0, bits_s1[62:52]};
			mant  = {12'd0, bits_s1[51:0]};
			neg   = bits_s1[63];
			mb    = 6'd52;
			bias  = 11'd1023;
			maxe  = 6'd62;
		end else begin
			field = {4'd0, b32[30:23]};
			mant  = {41'd0, b32[22:0]};
			neg   = b32[31];
			mb    = 6'd23;
			bias  = 11'd127;
			maxe  = 6'd30;
		end
	end

	// exponent range, integer check, magnitude and rounding interval
	always_comb begin
		ex    = $signed({2'b00, field}) - $signed({3'b000, bias});
		full  = (64'd1 << mb) | mant;
		rsh   = 6'(mb - ex[5:0]);
		lsh   = 6'(ex[5:0] - mb);
		fmask = ~(~64'd0 << rsh);
		side  = '0;
		mag   = 64'd0;
		if (ex < $signed({8'd0, mb})) begin
			mag = full >> rsh;
		end else begin
			mag = full << lsh;
		end
		shift = lsh[3:0];
		half  = 10'd1 << (shift - 4'd1);
		lower = (mant == 64'd0) ? (half >> 1) : half;
		side.neg   = neg;
		side.shift = shift;
		side.lo    = lower - {9'd0, mant[0]};
		side.hi    = half - {9'd0, mant[0]};
		side.rnd   = ex > $signed({8'd0, mb} + 14'sd1);
		side.nh    = 1'b0;
		if (kind_s1 == KIND_NONE) begin
			side.nh = 1'b1;
		end else if (field == 12'd0 && mant == 64'd0) begin
			mag      = 64'd0;
			side.neg = 1'b0;
			side.rnd = 1'b0;
		end else if (ex < 14'sd0 || ex > $signed({8'd0, maxe})) begin
			side.nh = 1'b1;
		end else if (ex < $signed({8'd0, mb}) && (mant & fmask) != 64'd0) begin
			side.nh = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag;
			side_s2 <= side;
		end
	end

endmodule
`default_nettype wire

// File: rtl/fisd_dabble.sv
`default_nettype none
module fisd_dabble #(
	parameter int STAGE = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       v_in,
	input  wire logic [63:0]                mag_in,
	input  wire logic [fisd_pkg::BCDW-1:0]  bcd_in,
	input  wire fisd_pkg::side_t            side_in,
	output logic                            v_q,
	output logic [63:0]                     mag_q,
	output logic [fisd_pkg::BCDW-1:0]       bcd_q,
	output fisd_pkg::side_t                 side_q
);
	import fisd_pkg::*;

	localparam int TOP = 63 - STAGE * BITS_PER_STAGE;

	logic [BCDW-1:0] bcd_n;

	// several conversion steps, msb first
	always_comb begin
		bcd_n = bcd_in;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			bcd_n = dd_step(bcd_n, mag_in[TOP - i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q  <= mag_in;
			bcd_q  <= bcd_n;
			side_q <= side_in;
		end
	end

endmodule
`default_nettype wire

// File: rtl/fisd_round.sv
`default_nettype none
module fisd_round (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       v_in,
	input  wire logic [fisd_pkg::BCDW-1:0]  bcd_in,
	input  wire fisd_pkg::side_t            side_in,
	output logic                            v_s12,
	output logic [fisd_pkg::BCDW-1:0]       bcd_s12,
	output logic                            nh_s12,
	output logic                            neg_s12
);
	import fisd_pkg::*;

	logic [13:0] rem [1:4];
	logic [13:0] pw  [1:4];
	logic [2:0]  k;
	logic        up;
	logic [13:0] dup;
	logic        dn_ok;
	logic        up_ok;
	logic        gate;

	// remainders from the low digits, choose the roundest power
	always_comb begin
		pw[1] = 14'd10;
		pw[2] = 14'd100;
		pw[3] = 14'd1000;
		pw[4] = 14'd10000;
		rem[1] = {10'd0, bcd_in[3:0]};
		rem[2] = rem[1] + 14'(bcd_in[7:4] * 7'd10);
		rem[3] = rem[2] + 14'(bcd_in[11:8] * 10'd100);
		rem[4] = rem[3] + 14'(bcd_in[15:12] * 14'd1000);
		k  = 3'd0;
		up = 1'b0;
		for (int p = 4; p >= 1; p--) begin
			dup   = pw[p] - rem[p];
			dn_ok = rem[p] <= {4'd0, side_in.lo};
			up_ok = dup <= {4'd0, side_in.hi};
			unique case (p)
				4: gate = side_in.shift >= 4'd10;
				3: gate = side_in.shift >= 4'd7;
				2: gate = side_in.shift >= 4'd3;
				default: gate = 1'b1;
			endcase
			if (side_in.rnd && gate && k == 3'd0 && (dn_ok || up_ok)) begin
				k  = 3'(p);
				up = up_ok && (!dn_ok || dup < rem[p]);
			end
		end
	end

	logic            v_s11;
	logic [BCDW-1:0] bcd_s11;
	logic [2:0]      k_s11;
	logic            up_s11;
	logic            nh_s11;
	logic            neg_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_in;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bcd_s11 <= bcd_in;
			k_s11   <= k;
			up_s11  <= up;
			nh_s11  <= side_in.nh;
			neg_s11 <= side_in.neg;
		end
	end

	logic [BCDW-1:0] bcd_r;
	logic            cy;

	// clear the low digits, then decimal increment above them when rounding up
	always_comb begin
		bcd_r = bcd_s11;
		for (int i = 0; i < NDIG; i++) begin
			cy = up_s11 && (i >= int'(k_s11));
			for (int j = 0; j < NDIG; j++) begin
				if (j >= int'(k_s11) && j < i && bcd_s11[j*4 +: 4] != 4'd9) begin
					cy = 1'b0;
				end
			end
			if (i < int'(k_s11)) begin
				bcd_r[i*4 +: 4] = 4'd0;
			end else if (cy) begin
				bcd_r[i*4 +: 4] = (bcd_s11[i*4 +: 4] == 4'd9) ? 4'd0 : bcd_s11[i*4 +: 4] + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bcd_s12 <= bcd_r;
			nh_s12  <= nh_s11;
			neg_s12 <= neg_s11;
		end
	end

endmodule
`default_nettype wire

// File: rtl/fisd_serial.sv
`default_nettype none
module fisd_serial (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       v_in,
	input  wire logic [fisd_pkg::BCDW-1:0]  bcd_in,
	input  wire logic                       nh_in,
	input  wire logic                       neg_in,
	output logic                            take,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [7:0]                      out_char,
	output logic                            last_char,
	output logic                            handled
);
	import fisd_pkg::*;

	logic            busy_q;
	logic [BCDW-1:0] dig_q;
	logic [4:0]      idx_q;
	logic            sign_q;
	logic            nh_q;
	logic [4:0]      top;
	logic            fire;

	// highest nonzero digit of the incoming value
	always_comb begin
		top = 5'd0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_in[i*4 +: 4] != 4'd0) begin
				top = 5'(i);
			end
		end
	end

	// character view of the held value
	always_comb begin
		out_valid = busy_q;
		handled   = !nh_q;
		last_char = nh_q || (!sign_q && idx_q == 5'd0);
		if (nh_q) begin
			out_char = 8'd0;
		end else if (sign_q) begin
			out_char = CH_MINUS;
		end else begin
			out_char = CH_ZERO + {4'd0, dig_q[idx_q*4 +: 4]};
		end
		fire = busy_q && out_ready;
		take = v_in && (!busy_q || (fire && last_char));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (fire && last_char) begin
			busy_q <= 1'b0;
		end
	end

	// load a new value or step to the next character
	always_ff @(posedge clk) begin
		if (take) begin
			dig_q  <= bcd_in;
			idx_q  <= top;
			sign_q <= neg_in && !nh_in;
			nh_q   <= nh_in;
		end else if (fire && !last_char) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 5'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/float_integer_shortest_decimal_top.sv
`default_nettype none
// channel | signals                          | moves
// input   | in_valid, in_ready, kind, bits   | one float bit pattern per transaction
// output  | out_valid, out_ready, out_char,  | one character per transaction
//         | last_char, handled               |
// with the pipe empty, the first character is offered once the input has passed the decode,
// conversion and rounding registers and has been loaded into the serializer.
// one value per cycle enters the pipeline while in_ready is high; the character serializer
// sends one character per cycle while out_ready is high; a value has up to 20 characters.
// the whole pipeline advances together; it holds while its last stage waits on the serializer.
// reset clears all valid bits; payload registers are not reset.
module float_integer_shortest_decimal_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [63:0] bits,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_char,
	output logic             last_char,
	output logic             handled
);
	import fisd_pkg::*;

	logic            en;
	logic            take;
	logic            v_c    [0:DABBLE_STAGES];
	logic [63:0]     mag_c  [0:DABBLE_STAGES];
	logic [BCDW-1:0] bcd_c  [0:DABBLE_STAGES];
	side_t           side_c [0:DABBLE_STAGES];
	logic            v_s12;
	logic [BCDW-1:0] bcd_s12;
	logic            nh_s12;
	logic            neg_s12;

	// pipeline moves when its last stage is empty or handed over
	assign en       = !v_s12 || take;
	assign in_ready = en;

	fisd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (in_valid),
		.kind    (kind),
		.bits    (bits),
		.v_s2    (v_c[0]),
		.mag_s2  (mag_c[0]),
		.side_s2 (side_c[0])
	);

	assign bcd_c[0] = '0;

	// binary to bcd conversion stages
	for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
		fisd_dabble #(.STAGE(g)) u_dabble (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (v_c[g]),
			.mag_in  (mag_c[g]),
			.bcd_in  (bcd_c[g]),
			.side_in (side_c[g]),
			.v_q     (v_c[g+1]),
			.mag_q   (mag_c[g+1]),
			.bcd_q   (bcd_c[g+1]),
			.side_q  (side_c[g+1])
		);
	end

	fisd_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_c[DABBLE_STAGES]),
		.bcd_in  (bcd_c[DABBLE_STAGES]),
		.side_in (side_c[DABBLE_STAGES]),
		.v_s12   (v_s12),
		.bcd_s12 (bcd_s12),
		.nh_s12  (nh_s12),
		.neg_s12 (neg_s12)
	);

	fisd_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_s12),
		.bcd_in    (bcd_s12),
		.nh_in     (nh_s12),
		.neg_in    (neg_s12),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last_char (last_char),
		.handled   (handled)
	);

endmodule
`default_nettype wire

// File: rtl/fisd_checker.sv
`default_nettype none
module fisd_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_char,
	input  wire logic       last_char,
	input  wire logic       handled
);
	import fisd_pkg::*;

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
		else $error("output changed while stalled");

	// not handled is a single zero result
	a_nh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !handled |-> last_char && out_char == 8'd0)
		else $error("bad not handled result");

	// handled characters are a sign or a digit
	a_chr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && handled |-> out_char == CH_MINUS ||
		(out_char >= CH_ZERO && out_char <= 8'h39))
		else $error("bad character");

	// text continues at once with a handled digit
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_char |=> out_valid && handled && out_char != CH_MINUS)
		else $error("text broken");

endmodule

bind float_integer_shortest_decimal_top fisd_checker u_fisd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_char  (out_char),
	.last_char (last_char),
	.handled   (handled)
);
`default_nettype wire
